// ===== rtl/scfc_pkg.sv =====
// Package for the serial command frame checker.
// Holds frame codes, limits and the evaluation result type; no dependencies.
package scfc_pkg;

	localparam int FRAME_BYTES = 7;
	localparam int POS_W = $clog2(FRAME_BYTES);
	localparam int REPLY_BYTES = 6;
	localparam int CNT_W = $clog2(REPLY_BYTES);
	localparam logic [CNT_W-1:0] REPLY_LAST = CNT_W'(REPLY_BYTES - 1);

	localparam logic [7:0] END_MARK = 8'h03;
	localparam logic [7:0] START_MARK = 8'h02;
	localparam logic [7:0] REPLY_LEN = 8'h01;
	localparam logic [7:0] ST_OK = 8'hAA;
	localparam logic [7:0] ST_BAD_SUM = 8'hFF;
	localparam logic [7:0] ST_BAD_VAL = 8'h55;

	localparam logic [7:0] LEN_ONE = 8'h01;
	localparam logic [7:0] LEN_TWO = 8'h02;
	localparam logic [7:0] OP_ON = 8'h01;
	localparam logic [7:0] OP_SET_FREQ = 8'h02;
	localparam logic [7:0] OP_OFF = 8'h03;

	localparam logic [11:0] FREQ_LOW = 12'h00A;
	localparam logic [11:0] FREQ_HIGH = 12'h3E8;

	typedef enum logic [1:0] {
		ACT_NONE = 2'd0,
		ACT_ON = 2'd1,
		ACT_GEN = 2'd2,
		ACT_OFF = 2'd3
	} action_t;

	typedef logic [7:0] byte_t;

	typedef struct packed {
		logic [7:0] opcode;
		logic [7:0] status;
		logic [7:0] check;
		action_t action;
		logic [9:0] freq_out;
		logic freq_we;
		logic [9:0] freq_new;
	} eval_t;

endpackage

// ===== rtl/scfc_eval.sv =====
// Frame evaluation: checksum, value check, frequency update and reply fields.
// Depends on scfc_pkg.
module scfc_eval import scfc_pkg::*; (
	input byte_t frame [FRAME_BYTES],
	input logic [9:0] freq_cur,
	output eval_t res
);

	byte_t x4;
	byte_t x5;
	logic sum_ok;
	logic val_ok;
	logic in_range;
	logic [11:0] f;
	logic [9:0] freq_new;
	byte_t status;
	action_t act;

	always_comb begin
		x4 = frame[0] ^ frame[1] ^ frame[2] ^ frame[3];
		x5 = x4 ^ frame[4];
		if (frame[2] == LEN_ONE) begin
			sum_ok = (frame[4] == x4);
		end else if (frame[2] == LEN_TWO) begin
			sum_ok = (frame[5] == x5);
		end else begin
			sum_ok = 1'b0;
		end

		if (frame[2] == LEN_ONE) begin
			f = {4'b0, frame[3]};
		end else if (frame[2] == LEN_TWO) begin
			f = {frame[3], 4'b0} | {4'b0, frame[4]};
		end else begin
			f = {2'b0, freq_cur};
		end
		in_range = (f >= FREQ_LOW) && (f <= FREQ_HIGH);
		freq_new = in_range ? f[9:0] : 10'd0;

		if (frame[1] == OP_SET_FREQ) begin
			val_ok = in_range;
		end else begin
			val_ok = (frame[2] == LEN_ONE) && (frame[3] == 8'h00);
		end

		if (!sum_ok) begin
			status = ST_BAD_SUM;
		end else if (!val_ok) begin
			status = ST_BAD_VAL;
		end else begin
			status = ST_OK;
		end

		act = ACT_NONE;
		if (sum_ok && val_ok) begin
			if (frame[1] == OP_ON) begin
				act = ACT_ON;
			end else if (frame[1] == OP_SET_FREQ) begin
				act = ACT_GEN;
			end else if (frame[1] == OP_OFF) begin
				act = ACT_OFF;
			end
		end

		res.opcode = frame[1];
		res.status = status;
		res.check = START_MARK ^ frame[1] ^ REPLY_LEN ^ status;
		res.action = act;
		res.freq_out = (act == ACT_GEN) ? freq_new : 10'd0;
		res.freq_we = (frame[1] == OP_SET_FREQ);
		res.freq_new = freq_new;
	end

endmodule

// ===== rtl/serial_command_frame_checker_core.sv =====
// Serial command frame checker top level: frame store, evaluation stage and reply sender.
// Depends on scfc_pkg and scfc_eval.
// The closing 0x03 word registers into close_s1, then the reply registers and rvalid_q load.
// One input word per cycle; each closed frame sends six reply words, one per cycle
// while m_tready is high; input stalls only while a closed frame waits for the previous reply.
// Reset clears the write position, stored frequency and handshake state; the store is not reset.
module serial_command_frame_checker_core import scfc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [7:0] s_tdata, // [7:0] rx_byte
	output logic m_tvalid,
	input logic m_tready,
	output logic [23:0] m_tdata, // [7:0] tx_byte, [17:8] frequency_out, [23:18] zero
	output logic m_tlast, // last_byte
	output logic [1:0] m_tuser // [1:0] action
);

	byte_t frame_q [FRAME_BYTES];
	logic [POS_W-1:0] wp_q;
	logic [9:0] freq_q;
	logic close_s1;
	logic rvalid_q;
	logic [CNT_W-1:0] cnt_q;
	byte_t opcode_q;
	byte_t status_q;
	byte_t check_q;
	action_t action_q;
	logic [9:0] fout_q;

	eval_t ev;
	logic in_acc;
	logic out_acc;
	logic load;
	logic closing;
	byte_t tx;

	scfc_eval u_eval (
		.frame(frame_q),
		.freq_cur(freq_q),
		.res(ev)
	);

	assign out_acc = m_tvalid && m_tready;
	assign load = close_s1 && (!rvalid_q || (out_acc && cnt_q == REPLY_LAST));
	assign s_tready = !close_s1 || load;
	assign in_acc = s_tvalid && s_tready;
	assign closing = (s_tdata == END_MARK) &&
		((wp_q == POS_W'(FRAME_BYTES - 2)) || (wp_q == POS_W'(FRAME_BYTES - 1)));

	always_ff @(posedge clk) begin
		if (in_acc) begin
			frame_q[wp_q] <= s_tdata;
		end
		if (load) begin
			opcode_q <= ev.opcode;
			status_q <= ev.status;
			check_q <= ev.check;
			action_q <= ev.action;
			fout_q <= ev.freq_out;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			freq_q <= '0;
			close_s1 <= 1'b0;
			rvalid_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (in_acc) begin
				if (closing || wp_q == POS_W'(FRAME_BYTES - 1)) begin
					wp_q <= '0;
				end else begin
					wp_q <= wp_q + POS_W'(1);
				end
				close_s1 <= closing;
			end else if (load) begin
				close_s1 <= 1'b0;
			end
			if (load && ev.freq_we) begin
				freq_q <= ev.freq_new;
			end
			if (load) begin
				rvalid_q <= 1'b1;
				cnt_q <= '0;
			end else if (out_acc) begin
				if (cnt_q == REPLY_LAST) begin
					rvalid_q <= 1'b0;
					cnt_q <= '0;
				end else begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
		end
	end

	always_comb begin
		case (cnt_q)
			CNT_W'(0): tx = START_MARK;
			CNT_W'(1): tx = opcode_q;
			CNT_W'(2): tx = REPLY_LEN;
			CNT_W'(3): tx = status_q;
			CNT_W'(4): tx = check_q;
			default: tx = END_MARK;
		endcase
	end

	assign m_tvalid = rvalid_q;
	assign m_tdata = {6'b0, (cnt_q == '0) ? fout_q : 10'd0, tx};
	assign m_tlast = (cnt_q == REPLY_LAST);
	assign m_tuser = (cnt_q == '0) ? action_q : ACT_NONE;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		rvalid_q |-> (cnt_q <= REPLY_LAST))
		else $error("reply counter out of range");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (close_s1 && rvalid_q))
		else $error("input stalled without a waiting frame");

	a_wp_range: assert property (@(posedge clk) disable iff (!arst_n)
		wp_q <= POS_W'(FRAME_BYTES - 1))
		else $error("write position out of range");

	a_close_resets_wp: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && closing) |=> (wp_q == '0 && close_s1))
		else $error("frame close did not restart the store");

endmodule
